// File: rtl/psr_pkg.sv
// ----------------------------------------------------------------------------
// psr_pkg - shared types and constants for the steering speed ramp
// Field widths, controller constants, register indexes and the record
// that carries one tick from the state stage to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package psr_pkg;

  // Field widths
  localparam int ERR_W     = 10;
  localparam int GAIN_W    = 10;
  localparam int SPD_W     = 10;
  localparam int DRV_W     = 13;
  localparam int INTEG_W   = 18;
  localparam int DERIV_W   = ERR_W + 1;
  localparam int PROD_P_W  = ERR_W + GAIN_W + 1;
  localparam int PROD_D_W  = DERIV_W + GAIN_W + 1;
  localparam int CORR_W    = PROD_D_W + 1;
  localparam int REG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_MAX  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_MIN  = 2'd3;

  // Configuration reset values
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 10'd1;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 10'd0;
  localparam logic [SPD_W-1:0]  SPEED_MAX_RST  = 10'd1000;
  localparam logic [SPD_W-1:0]  SPEED_MIN_RST  = 10'd0;

  // Controller constants
  localparam int INTEG_LIMIT = 100000;
  localparam int NEAR_SPEED  = 1000;
  localparam int RAMP_STEP   = 20;
  localparam int DRIVE_MAX   = 4095;
  localparam int DRIVE_MIN   = -4096;

  localparam logic [1:0] RAMP_TICKS = 2'd3;

  localparam logic signed [ERR_W-1:0] BIG_ERR_POS = 10'sd100;
  localparam logic signed [ERR_W-1:0] BIG_ERR_NEG = -10'sd100;
  localparam logic signed [ERR_W-1:0] ERR_LOST    = -10'sd1;

  // Divide by 1000 as multiply by ceil(2^26/1000), exact for |x| <= 100000
  localparam int MAG_W       = INTEG_W - 1;
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 26;
  localparam int QUOT_W      = 7;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 17'd67109;

  // One tick leaving the state stage
  typedef struct packed {
    logic signed [PROD_P_W-1:0] p_term;
    logic signed [PROD_D_W-1:0] d_term;
    logic signed [INTEG_W-1:0]  integ;
    logic        [SPD_W-1:0]    speed;
  } track_t;

endpackage

`default_nettype wire

// File: rtl/pid_steering_speed_ramp.sv
// ----------------------------------------------------------------------------
// pid_steering_speed_ramp - differential drive steering controller
//
// One input transfer per control tick carries a signed bearing error and a
// near-target flag; one result transfer returns the left and right drive
// commands and the forward speed. Both channels use valid/ready.
// Gains and speed limits are written through the cfg_ port; the user must
// write them only while the block is idle, which the block does not enforce.
// A write takes effect at the clock edge where cfg_we is high. The datapath
// is a four-register pipeline: input register, state and gain products,
// integral divide and product sum, result register. Each item passes them
// in turn; one item is taken every cycle while the receiver keeps out_ready high.
// When out_ready is low with a result waiting, the whole pipeline holds and
// in_ready falls; nothing is dropped.
// Reset clears the error history, integral, speed level, ramp counter and
// all valid flags, and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_steering_speed_ramp
  import psr_pkg::*;
#(
  parameter int DERIV_LAG = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [ERR_W-1:0]     in_bearing_error,
  input  wire logic                        in_target_near,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [DRV_W-1:0]          out_left_drive,
  output logic signed [DRV_W-1:0]          out_right_drive,
  output logic        [SPD_W-1:0]          out_forward_speed,
  input  wire logic                        cfg_we,
  input  wire logic        [REG_IDX_W-1:0] cfg_index,
  input  wire logic        [GAIN_W-1:0]    cfg_wdata
);

  logic                    pipe_adv;
  logic                    s0_vld_r;
  logic signed [ERR_W-1:0] s0_err_r;
  logic                    s0_near_r;
  logic        [GAIN_W-1:0] prop_gain_r;
  logic        [GAIN_W-1:0] deriv_gain_r;
  logic        [SPD_W-1:0]  speed_max_r;
  logic        [SPD_W-1:0]  speed_min_r;
  logic                    trk_vld;
  track_t                  trk;

  // Advance the pipeline unless a result waits on a stalled receiver
  assign pipe_adv = !out_valid || out_ready;
  assign in_ready = pipe_adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= PROP_GAIN_RST;
      deriv_gain_r <= DERIV_GAIN_RST;
      speed_max_r  <= SPEED_MAX_RST;
      speed_min_r  <= SPEED_MIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP_GAIN:  prop_gain_r  <= cfg_wdata;
        REG_DERIV_GAIN: deriv_gain_r <= cfg_wdata;
        REG_SPEED_MAX:  speed_max_r  <= cfg_wdata;
        REG_SPEED_MIN:  speed_min_r  <= cfg_wdata;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (pipe_adv) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      s0_err_r  <= in_bearing_error;
      s0_near_r <= in_target_near;
    end
  end

  psr_track #(
    .DERIV_LAG (DERIV_LAG)
  ) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (pipe_adv),
    .in_vld     (s0_vld_r),
    .err        (s0_err_r),
    .near       (s0_near_r),
    .prop_gain  (prop_gain_r),
    .deriv_gain (deriv_gain_r),
    .speed_max  (speed_max_r),
    .speed_min  (speed_min_r),
    .trk_vld    (trk_vld),
    .trk        (trk)
  );

  psr_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (pipe_adv),
    .trk_vld   (trk_vld),
    .trk       (trk),
    .out_vld   (out_valid),
    .out_left  (out_left_drive),
    .out_right (out_right_drive),
    .out_speed (out_forward_speed)
  );

endmodule

`default_nettype wire

// File: rtl/psr_track.sv
// ----------------------------------------------------------------------------
// psr_track - controller state and gain products
// Keeps the error history, integral, speed level and ramp counter, and
// registers the proportional and derivative products of each tick.
// ----------------------------------------------------------------------------
`default_nettype none

module psr_track
  import psr_pkg::*;
#(
  parameter int DERIV_LAG = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     adv,
  input  wire logic                     in_vld,
  input  wire logic signed [ERR_W-1:0]  err,
  input  wire logic                     near,
  input  wire logic        [GAIN_W-1:0] prop_gain,
  input  wire logic        [GAIN_W-1:0] deriv_gain,
  input  wire logic        [SPD_W-1:0]  speed_max,
  input  wire logic        [SPD_W-1:0]  speed_min,
  output logic                          trk_vld,
  output track_t                        trk
);

  localparam int SPD_X_W = SPD_W + 2;
  localparam logic signed [INTEG_W:0] SUM_HI = (INTEG_W+1)'(INTEG_LIMIT);
  localparam logic signed [INTEG_W:0] SUM_LO = (INTEG_W+1)'(-INTEG_LIMIT);

  logic signed [ERR_W-1:0]   hist_r [DERIV_LAG];
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [INTEG_W-1:0] integ_nxt;
  logic signed [INTEG_W:0]   integ_sum;
  logic        [SPD_W-1:0]   speed_r;
  logic        [SPD_W-1:0]   speed_nxt;
  logic        [1:0]         ramp_r;
  logic        [1:0]         ramp_nxt;
  logic        [1:0]         ramp_inc;
  logic signed [SPD_X_W-1:0] spd_base;
  logic signed [SPD_X_W-1:0] spd_step;
  logic signed [SPD_X_W-1:0] spd_hi;
  logic signed [SPD_X_W-1:0] spd_lo;
  logic                      big_err;
  logic                      take;
  logic signed [DERIV_W-1:0] deriv;
  logic signed [GAIN_W:0]    pg_s;
  logic signed [GAIN_W:0]    dg_s;
  logic                      trk_vld_r;
  track_t                    trk_r;
  track_t                    trk_nxt;

  assign take = adv && in_vld;

  // Lagged derivative against the oldest history entry
  assign deriv = DERIV_W'(err) - DERIV_W'(hist_r[DERIV_LAG-1]);

  // Accumulate and clamp the integral; a zero error clears it
  assign integ_sum = (INTEG_W+1)'(integ_r) + (INTEG_W+1)'(err);

  always_comb begin
    priority if (err == '0) begin
      integ_nxt = '0;
    end else if (integ_sum > SUM_HI) begin
      integ_nxt = INTEG_W'(INTEG_LIMIT);
    end else if (integ_sum < SUM_LO) begin
      integ_nxt = INTEG_W'(-INTEG_LIMIT);
    end else begin
      integ_nxt = integ_sum[INTEG_W-1:0];
    end
  end

  // Speed ramp: preset on near target, then drop, step up or hold
  assign big_err  = (err > BIG_ERR_POS) || (err < BIG_ERR_NEG) || (err == ERR_LOST);
  assign ramp_inc = ramp_r + 2'd1;
  assign spd_base = near ? SPD_X_W'(NEAR_SPEED) : SPD_X_W'({1'b0, speed_r});
  assign spd_hi   = SPD_X_W'({1'b0, speed_max});
  assign spd_lo   = SPD_X_W'({1'b0, speed_min});

  always_comb begin
    spd_step = spd_base;
    ramp_nxt = ramp_r;
    if (big_err) begin
      spd_step = spd_base - SPD_X_W'(1);
    end else if (ramp_inc == RAMP_TICKS) begin
      spd_step = spd_base + SPD_X_W'(RAMP_STEP);
      ramp_nxt = '0;
    end else begin
      ramp_nxt = ramp_inc;
    end
  end

  // Clamp to the limits, upper bound first
  always_comb begin
    priority if (spd_step > spd_hi) begin
      speed_nxt = speed_max;
    end else if (spd_step < spd_lo) begin
      speed_nxt = speed_min;
    end else begin
      speed_nxt = spd_step[SPD_W-1:0];
    end
  end

  // Gain products for the correction
  assign pg_s = {1'b0, prop_gain};
  assign dg_s = {1'b0, deriv_gain};

  always_comb begin
    trk_nxt.p_term = PROD_P_W'(err) * PROD_P_W'(pg_s);
    trk_nxt.d_term = PROD_D_W'(deriv) * PROD_D_W'(dg_s);
    trk_nxt.integ  = integ_nxt;
    trk_nxt.speed  = speed_nxt;
  end

  // Update state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DERIV_LAG; i++) begin
        hist_r[i] <= '0;
      end
      integ_r <= '0;
      speed_r <= '0;
      ramp_r  <= '0;
    end else if (take) begin
      hist_r[0] <= err;
      for (int i = 1; i < DERIV_LAG; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
      integ_r <= integ_nxt;
      speed_r <= speed_nxt;
      ramp_r  <= ramp_nxt;
    end
  end

  // Stage register toward the output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_vld_r <= 1'b0;
    end else if (adv) begin
      trk_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      trk_r <= trk_nxt;
    end
  end

  assign trk_vld = trk_vld_r;
  assign trk     = trk_r;

  // The ramp counter wraps before reaching the step count
  a_ramp_range: assert property (@(posedge clk) disable iff (!rst_n)
    ramp_r != RAMP_TICKS)
    else $error("ramp counter reached step count");

  // The integral stays within its clamp
  a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
    (integ_r <= SUM_HI[INTEG_W-1:0] && !integ_r[INTEG_W-1])
    || (integ_r >= SUM_LO[INTEG_W-1:0] && integ_r[INTEG_W-1]))
    else $error("integral outside clamp");

  // A zero error leaves a cleared integral
  a_integ_clear: assert property (@(posedge clk) disable iff (!rst_n)
    take && (err == '0) |=> integ_r == '0)
    else $error("integral not cleared on zero error");

endmodule

`default_nettype wire

// File: rtl/psr_mix.sv
// ----------------------------------------------------------------------------
// psr_mix - correction sum and drive outputs
// Divides the integral by 1000 toward zero, forms the correction and
// drives the saturated left and right commands from the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module psr_mix
  import psr_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    adv,
  input  wire logic                    trk_vld,
  input  wire track_t                  trk,
  output logic                         out_vld,
  output logic signed [DRV_W-1:0]      out_left,
  output logic signed [DRV_W-1:0]      out_right,
  output logic        [SPD_W-1:0]      out_speed
);

  localparam int PRD_W   = MAG_W + RECIP_W;
  localparam int DRV_X_W = CORR_W + 1;
  localparam logic signed [DRV_X_W-1:0] SAT_HI = DRV_X_W'(DRIVE_MAX);
  localparam logic signed [DRV_X_W-1:0] SAT_LO = DRV_X_W'(DRIVE_MIN);

  function automatic logic signed [DRV_W-1:0] sat_drive(
    input logic signed [DRV_X_W-1:0] v
  );
    logic signed [DRV_W-1:0] r;
    priority if (v > SAT_HI) begin
      r = DRV_W'(DRIVE_MAX);
    end else if (v < SAT_LO) begin
      r = DRV_W'(DRIVE_MIN);
    end else begin
      r = v[DRV_W-1:0];
    end
    return r;
  endfunction

  logic        [MAG_W-1:0]   mag;
  logic        [PRD_W-1:0]   prod;
  logic                      a_vld_r;
  logic        [QUOT_W-1:0]  a_q_r;
  logic                      a_neg_r;
  logic signed [CORR_W-1:0]  a_sum_r;
  logic        [SPD_W-1:0]   a_speed_r;
  logic signed [CORR_W-1:0]  q_s;
  logic signed [CORR_W-1:0]  corr;
  logic signed [DRV_X_W-1:0] spd_x;
  logic signed [DRV_X_W-1:0] left_x;
  logic signed [DRV_X_W-1:0] right_x;
  logic                      out_vld_r;
  logic signed [DRV_W-1:0]   out_left_r;
  logic signed [DRV_W-1:0]   out_right_r;
  logic        [SPD_W-1:0]   out_speed_r;

  // Integral magnitude times the reciprocal of 1000
  assign mag  = trk.integ[INTEG_W-1] ? MAG_W'(-trk.integ) : MAG_W'(trk.integ);
  assign prod = PRD_W'(mag) * PRD_W'(RECIP_MUL);

  // Hold quotient, sign and the product sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= trk_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_q_r     <= prod[RECIP_SHIFT +: QUOT_W];
      a_neg_r   <= trk.integ[INTEG_W-1];
      a_sum_r   <= CORR_W'(trk.p_term) + CORR_W'(trk.d_term);
      a_speed_r <= trk.speed;
    end
  end

  // Correction with signed quotient, then both drives
  assign q_s     = CORR_W'($signed({1'b0, a_q_r}));
  assign corr    = a_sum_r + (a_neg_r ? -q_s : q_s);
  assign spd_x   = DRV_X_W'($signed({1'b0, a_speed_r}));
  assign left_x  = spd_x + DRV_X_W'(corr);
  assign right_x = spd_x - DRV_X_W'(corr);

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_left_r  <= sat_drive(left_x);
      out_right_r <= sat_drive(right_x);
      out_speed_r <= a_speed_r;
    end
  end

  assign out_vld   = out_vld_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;
  assign out_speed = out_speed_r;

endmodule

`default_nettype wire
